// ----- rtl/ats_pkg.sv -----
// Shared types, token codes, character codes and the keyword table of the token scanner.
package ats_pkg;

  localparam int unsigned POS_BITS_DEF          = 16;
  localparam int unsigned LINE_BITS_DEF         = 16;
  localparam int unsigned MAX_KEYWORD_CHARS_DEF = 7;

  localparam int unsigned KIND_W     = 6;
  localparam int unsigned FIELD_W    = 16;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned NUM_KW     = 32;
  localparam int unsigned KW_IDX_W   = 5;
  localparam int unsigned KW_TEXT_W  = 64;
  localparam int unsigned OUT_DATA_W = 3 * FIELD_W + CHAR_W;

  localparam logic [KIND_W-1:0] KIND_EOF    = 6'd0;
  localparam logic [KIND_W-1:0] KIND_NUM    = 6'd1;
  localparam logic [KIND_W-1:0] KIND_SYM    = 6'd2;
  localparam logic [KIND_W-1:0] KIND_STR    = 6'd3;
  localparam logic [KIND_W-1:0] KIND_DOT    = 6'd4;
  localparam logic [KIND_W-1:0] KIND_COMMA  = 6'd5;
  localparam logic [KIND_W-1:0] KIND_COLON  = 6'd6;
  localparam logic [KIND_W-1:0] KIND_KW0    = 6'd7;
  localparam logic [KIND_W-1:0] KIND_BADCH  = 6'd39;
  localparam logic [KIND_W-1:0] KIND_UNTERM = 6'd40;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;

  // Keywords packed with the first character in the lowest byte.
  localparam logic [KW_TEXT_W-1:0] KW_TEXT [NUM_KW] = '{
    64'h746c6168,       64'h68737570,       64'h6268737570,     64'h706f7264,
    64'h62706f7264,     64'h646c,           64'h62646c,         64'h7473,
    64'h627473,         64'h777463,         64'h627463,         64'h646461,
    64'h62646461,       64'h627573,         64'h62627573,       64'h67656e,
    64'h6267656e,       64'h7165,           64'h627165,         64'h746c,
    64'h62746c,         64'h7467,           64'h627467,         64'h706d6a,
    64'h706d6a63,       64'h6c6c6163,       64'h746572,         64'h6c6c6163737973,
    64'h65747962,       64'h64726f77,       64'h6e7265747865,   64'h6c61626f6c67
  };

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [CHAR_W-1:0]  bad;
    logic [FIELD_W-1:0] len;
    logic [FIELD_W-1:0] off;
    logic [FIELD_W-1:0] line;
    logic               last;
  } token_t;

  function automatic logic is_letter(input logic [CHAR_W-1:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
  endfunction

  function automatic logic is_numeral(input logic [CHAR_W-1:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

endpackage

// ----- rtl/assembly_token_scanner.sv -----
// Top level of the token scanner: scan state, keyword match and two-entry result register.
// The scanner takes one source byte per cycle unless the result side holds it off, and
// its tokens appear on the result side the cycle after the byte is taken. A byte that
// ends an identifier or number and is itself a token (or end of source) yields two
// tokens in one beat; both go into the two-entry result register, and the input then
// stalls until the first token has left and the second is leaving. The rate is thus
// one byte per cycle save for those stalls, bounded by one token per cycle on the
// result side. After EOF or an error token the scanner takes and drops every byte until reset.
module assembly_token_scanner
  import ats_pkg::*;
#(
  parameter int unsigned POS_BITS          = POS_BITS_DEF,
  parameter int unsigned LINE_BITS         = LINE_BITS_DEF,
  parameter int unsigned MAX_KEYWORD_CHARS = MAX_KEYWORD_CHARS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [CHAR_W-1:0]     s_axis_tdata,   // src_byte
  input  logic                  s_axis_tlast,   // end_of_source
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // token_line, token_offset, token_length, bad_char
  output logic [KIND_W-1:0]     m_axis_tuser,   // tok_kind
  output logic                  m_axis_tlast    // last_of_run
);

  localparam int unsigned KW_BITS = CHAR_W * MAX_KEYWORD_CHARS;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_IDENT   = 3'd1;
  localparam logic [2:0] MODE_NUMBER  = 3'd2;
  localparam logic [2:0] MODE_STRING  = 3'd3;
  localparam logic [2:0] MODE_SLASH   = 3'd4;
  localparam logic [2:0] MODE_COMMENT = 3'd5;
  localparam logic [2:0] MODE_DONE    = 3'd6;

  logic [2:0]           mode_q, mode_d;
  logic [KW_BITS-1:0]   kw_buf_q, kw_buf_d;
  logic [POS_BITS-1:0]  len_q, len_d;
  logic [POS_BITS-1:0]  start_q, start_d;
  logic [POS_BITS-1:0]  pos_q, pos_d;
  logic [LINE_BITS-1:0] line_q, line_d;

  logic                 slot0_v_q, slot1_v_q;
  token_t               slot0_q, slot1_q;

  logic                 accept, pop, ended, rescan;
  logic [CHAR_W-1:0]    c;
  logic [POS_BITS-1:0]  pos_inc, len_inc;
  logic                 kw_hit;
  logic [KW_IDX_W-1:0]  kw_idx;
  logic [KIND_W-1:0]    ident_kind;
  logic                 tok_a_v, tok_b_v;
  token_t               tok_a, tok_b, res0, res1;

  assign c       = s_axis_tdata;
  assign ended   = s_axis_tlast || (c == CH_NUL);
  assign pop     = slot0_v_q && m_axis_tready;
  // Room for two tokens must be left once the head beat has gone.
  assign s_axis_tready = !slot0_v_q || (m_axis_tready && !slot1_v_q);
  assign accept  = s_axis_tvalid && s_axis_tready;

  assign pos_inc = (pos_q == '1) ? pos_q : pos_q + POS_BITS'(1);
  assign len_inc = (len_q == '1) ? len_q : len_q + POS_BITS'(1);

  always_comb begin
    kw_hit = 1'b0;
    kw_idx = '0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (!kw_hit && KW_TEXT_W'(kw_buf_q) == KW_TEXT[k]) begin
        kw_hit = 1'b1;
        kw_idx = KW_IDX_W'(k);
      end
    end
    if (len_q > POS_BITS'(MAX_KEYWORD_CHARS) || !kw_hit) begin
      ident_kind = KIND_SYM;
    end else begin
      ident_kind = KIND_KW0 + KIND_W'(kw_idx);
    end
  end

  always_comb begin
    mode_d   = mode_q;
    kw_buf_d = kw_buf_q;
    len_d    = len_q;
    start_d  = start_q;
    pos_d    = pos_q;
    line_d   = line_q;
    rescan   = 1'b0;
    tok_a_v  = 1'b0;
    tok_b_v  = 1'b0;
    tok_a    = '0;
    tok_b    = '0;

    unique case (mode_q) inside
      MODE_IDENT, MODE_NUMBER: begin
        if (!ended && (mode_q == MODE_IDENT ? (is_letter(c) || is_numeral(c))
                                           : is_numeral(c))) begin
          if (mode_q == MODE_IDENT) begin
            for (int i = 0; i < MAX_KEYWORD_CHARS; i++) begin
              if (len_q == POS_BITS'(i)) begin
                kw_buf_d[CHAR_W*i +: CHAR_W] = c;
              end
            end
          end
          len_d = len_inc;
          pos_d = pos_inc;
        end else begin
          tok_a_v    = 1'b1;
          tok_a.kind = (mode_q == MODE_IDENT) ? ident_kind : KIND_NUM;
          tok_a.off  = FIELD_W'(start_q);
          tok_a.len  = FIELD_W'(len_q);
          mode_d     = MODE_IDLE;
          rescan     = 1'b1;
        end
      end
      MODE_STRING: begin
        if (ended) begin
          tok_a_v    = 1'b1;
          tok_a.kind = KIND_UNTERM;
          tok_a.off  = FIELD_W'(start_q);
          tok_a.len  = FIELD_W'(len_q);
          mode_d     = MODE_DONE;
        end else if (c == CH_QUOTE) begin
          tok_a_v    = 1'b1;
          tok_a.kind = KIND_STR;
          tok_a.off  = FIELD_W'(start_q);
          tok_a.len  = FIELD_W'(len_q);
          mode_d     = MODE_IDLE;
          pos_d      = pos_inc;
        end else begin
          len_d = len_inc;
          pos_d = pos_inc;
        end
      end
      MODE_SLASH: begin
        if (!ended && c == CH_SLASH) begin
          mode_d = MODE_COMMENT;
          pos_d  = pos_inc;
        end else begin
          tok_a_v    = 1'b1;
          tok_a.kind = KIND_BADCH;
          tok_a.off  = FIELD_W'(start_q);
          tok_a.len  = FIELD_W'(1);
          tok_a.bad  = CH_SLASH;
          mode_d     = MODE_DONE;
        end
      end
      MODE_COMMENT: begin
        if (!ended && c != CH_LF) begin
          pos_d = pos_inc;
        end else begin
          mode_d = MODE_IDLE;
          rescan = 1'b1;
        end
      end
      MODE_DONE: begin
      end
      default: begin
        rescan = 1'b1;
      end
    endcase

    // The current byte is scanned from scratch once any lexeme before it has closed.
    if (rescan) begin
      if (ended) begin
        tok_b_v    = 1'b1;
        tok_b.kind = KIND_EOF;
        tok_b.off  = FIELD_W'(pos_q);
        mode_d     = MODE_DONE;
      end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
        if (c == CH_LF && line_q != '1) begin
          line_d = line_q + LINE_BITS'(1);
        end
        pos_d = pos_inc;
      end else if (c == CH_SLASH) begin
        start_d = pos_q;
        mode_d  = MODE_SLASH;
        pos_d   = pos_inc;
      end else if (c == CH_DOT || c == CH_COMMA || c == CH_COLON) begin
        tok_b_v    = 1'b1;
        tok_b.kind = (c == CH_DOT) ? KIND_DOT : ((c == CH_COMMA) ? KIND_COMMA : KIND_COLON);
        tok_b.off  = FIELD_W'(pos_q);
        tok_b.len  = FIELD_W'(1);
        pos_d      = pos_inc;
      end else if (c == CH_QUOTE) begin
        mode_d  = MODE_STRING;
        start_d = pos_inc;
        len_d   = '0;
        pos_d   = pos_inc;
      end else if (is_letter(c) || is_numeral(c)) begin
        mode_d   = is_letter(c) ? MODE_IDENT : MODE_NUMBER;
        start_d  = pos_q;
        len_d    = POS_BITS'(1);
        kw_buf_d = KW_BITS'(c);
        pos_d    = pos_inc;
      end else begin
        tok_b_v    = 1'b1;
        tok_b.kind = KIND_BADCH;
        tok_b.off  = FIELD_W'(pos_q);
        tok_b.len  = FIELD_W'(1);
        tok_b.bad  = c;
        mode_d     = MODE_DONE;
      end
    end

    tok_a.line = FIELD_W'(line_q);
    tok_b.line = FIELD_W'(line_q);
    res0       = tok_a_v ? tok_a : tok_b;
    res0.last  = !(tok_a_v && tok_b_v);
    res1       = tok_b;
    res1.last  = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      kw_buf_q <= '0;
      len_q    <= '0;
      start_q  <= '0;
      pos_q    <= '0;
      line_q   <= LINE_BITS'(1);
    end else if (accept) begin
      mode_q   <= mode_d;
      kw_buf_q <= kw_buf_d;
      len_q    <= len_d;
      start_q  <= start_d;
      pos_q    <= pos_d;
      line_q   <= line_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot0_v_q <= 1'b0;
      slot1_v_q <= 1'b0;
    end else if (accept) begin
      slot0_v_q <= tok_a_v || tok_b_v;
      slot1_v_q <= tok_a_v && tok_b_v;
    end else if (pop) begin
      slot0_v_q <= slot1_v_q;
      slot1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot0_q <= res0;
      slot1_q <= res1;
    end else if (pop) begin
      slot0_q <= slot1_q;
    end
  end

  assign m_axis_tvalid = slot0_v_q;
  assign m_axis_tdata  = {slot0_q.bad, slot0_q.len, slot0_q.off, slot0_q.line};
  assign m_axis_tuser  = slot0_q.kind;
  assign m_axis_tlast  = slot0_q.last;

  a_slot_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot1_v_q |-> slot0_v_q)
    else $error("second result slot holds a token while the head is empty");

  a_accept_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !slot1_v_q)
    else $error("byte taken while the result register is still full");

  a_run_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> slot1_v_q)
    else $error("open run without its closing token queued");

  a_done_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_DONE) |=> (mode_q == MODE_DONE))
    else $error("scanner left the finished state without reset");

  a_line_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (line_q >= $past(line_q)))
    else $error("line count went backward");

endmodule
